### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the module clock, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true at a sampled clock edge.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### hw/rtl/lrs_pkg.sv
`timescale 1ns / 1ps

package lrs_pkg;

   localparam int DATA_W      = 8;
   localparam int COEFF_W     = 24;
   localparam int INDEX_W     = 8;
   localparam int MODULUS_W   = 23;
   localparam int PARTIAL_W   = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 23;

   localparam logic [MODULUS_W-1:0] MODULUS_RESET = 23'd8380417;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS     = 1'b1;

   typedef enum logic [1:0] {
      MODE_UNIFORM = 2'd0,
      MODE_ETA2    = 2'd1,
      MODE_ETA4    = 2'd2,
      MODE_UNUSED  = 2'd3
   } sample_mode_type;

   typedef struct packed {
      logic [COEFF_W-1:0] coeff;
      logic [INDEX_W-1:0] coeff_index;
      logic               poly_done;
   } result_type;

   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic               ok;
      logic [COEFF_W-1:0] value;
   } eta_result_type;

   // Eta nibble mapping; the remainder by five uses the 205 / 1024 reciprocal.
   function automatic eta_result_type eta_map(input logic [3:0] nib,
                                              input sample_mode_type mode);
      logic [11:0]    prod;
      logic [3:0]     rem;
      eta_result_type r;
      prod = 12'd205 * {8'd0, nib};
      rem  = nib - 4'({2'b00, prod[11:10]} * 4'd5);
      if (mode == MODE_ETA2) begin
         r.ok    = (nib < 4'd15);
         r.value = 24'd2 - {20'd0, rem};
      end else begin
         r.ok    = (nib < 4'd9);
         r.value = 24'd4 - {20'd0, nib};
      end
      return r;
   endfunction

endpackage

### hw/rtl/lrs_req_if.sv
`timescale 1ns / 1ps

interface lrs_req_if import lrs_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              new_poly;

   modport source (output valid, output data_byte, output new_poly, input ready);
   modport sink (input valid, input data_byte, input new_poly, output ready);
endinterface

### hw/rtl/lrs_rsp_if.sv
`timescale 1ns / 1ps

interface lrs_rsp_if import lrs_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COEFF_W-1:0] coeff;
   logic [INDEX_W-1:0] coeff_index;
   logic               poly_done;

   modport source (output valid, output coeff, output coeff_index, output poly_done,
                   input ready);
   modport sink (input valid, input coeff, input coeff_index, input poly_done,
                 output ready);
endinterface

### hw/rtl/lrs_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrs_front import lrs_pkg::*; #(
   parameter int COEFF_COUNT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   lrs_req_if.sink                req_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  queue_status_type       status,
   output logic                   push,
   output entry_type              push_data
);

   localparam int CW = $clog2(COEFF_COUNT + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(COEFF_COUNT);
   localparam logic [CW-1:0] COUNT_LAST = CW'(COEFF_COUNT - 1);

   sample_mode_type        mode_ff;
   logic [MODULUS_W-1:0]   modulus_ff;
   logic [CW-1:0]          cnt_ff, cnt_in, cnt_base, cnt1;
   logic [1:0]             phase_ff, phase_in, phase_base;
   logic [PARTIAL_W-1:0]   partial_ff, partial_in, partial_base;
   logic                   accept;
   logic                   found;
   logic                   hi_ok;
   logic [MODULUS_W-1:0]   sample;
   eta_result_type         lo_r, hi_r;

   function automatic result_type make_result(input logic [COEFF_W-1:0] value,
                                              input logic [CW-1:0] idx);
      result_type r;
      r.coeff       = value;
      r.coeff_index = INDEX_W'(idx);
      r.poly_done   = (idx == COUNT_LAST);
      return r;
   endfunction

   assign req_ch.ready = !status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign cnt_base     = req_ch.new_poly ? '0 : cnt_ff;
   assign phase_base   = req_ch.new_poly ? 2'd0 : phase_ff;
   assign partial_base = req_ch.new_poly ? '0 : partial_ff;

   assign sample = {req_ch.data_byte[6:0], partial_base};
   assign lo_r   = eta_map(req_ch.data_byte[3:0], mode_ff);
   assign hi_r   = eta_map(req_ch.data_byte[7:4], mode_ff);
   assign cnt1   = cnt_base + CW'(lo_r.ok);
   assign hi_ok  = hi_r.ok && (cnt1 < COUNT_MAX);

   always_comb begin
      cnt_in     = cnt_base;
      phase_in   = phase_base;
      partial_in = partial_base;
      push_data  = '0;
      found      = 1'b0;
      if (cnt_base < COUNT_MAX) begin
         case (mode_ff)
            MODE_UNIFORM: begin
               case (phase_base)
                  2'd0: begin
                     partial_in = {8'd0, req_ch.data_byte};
                     phase_in   = 2'd1;
                  end
                  2'd1: begin
                     partial_in = {req_ch.data_byte, partial_base[7:0]};
                     phase_in   = 2'd2;
                  end
                  default: begin
                     partial_in = '0;
                     phase_in   = 2'd0;
                     if (sample < modulus_ff) begin
                        found           = 1'b1;
                        push_data.first = make_result({1'b0, sample}, cnt_base);
                        cnt_in          = cnt_base + CW'(1);
                     end
                  end
               endcase
            end
            MODE_ETA2, MODE_ETA4: begin
               partial_in = '0;
               phase_in   = 2'd0;
               cnt_in     = cnt1 + CW'(hi_ok);
               found      = lo_r.ok || hi_ok;
               if (lo_r.ok) begin
                  push_data.first  = make_result(lo_r.value, cnt_base);
                  push_data.second = make_result(hi_r.value, cnt1);
                  push_data.two    = hi_ok;
               end else begin
                  push_data.first  = make_result(hi_r.value, cnt_base);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push = accept && found;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_UNIFORM;
         modulus_ff <= MODULUS_RESET;
         cnt_ff     <= '0;
         phase_ff   <= 2'd0;
         partial_ff <= '0;
      end else begin
         if (csr_we && csr_index == CSR_SAMPLE_MODE) begin
            mode_ff <= sample_mode_type'(csr_wdata[1:0]);
         end
         if (csr_we && csr_index == CSR_MODULUS) begin
            modulus_ff <= csr_wdata;
         end
         if (accept) begin
            cnt_ff     <= cnt_in;
            phase_ff   <= phase_in;
            partial_ff <= partial_in;
         end
      end
   end

   `ASSERT_NEVER(count_in_range, cnt_ff > COUNT_MAX, "coefficient count past polynomial size")
   `ASSERT_CLK(second_needs_first, push && push_data.two |-> push_data.first.poly_done == 1'b0,
               "second coefficient pushed after the last one")

endmodule

### hw/rtl/lrs_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrs_queue import lrs_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_data,
   input  logic             pop,
   output entry_type        pop_data,
   output queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

   entry_type       slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [FW-1:0]   fill_ff;

   assign pop_data     = slot_ff[rd_ff];
   assign status.full  = (fill_ff == FILL_MAX);
   assign status.empty = (fill_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_LAST) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_LAST) ? '0 : rd_ff + PW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + FW'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - FW'(1);
         end
      end
   end

   `ASSERT_CLK(no_overflow, push |-> !status.full, "push into a full queue")
   `ASSERT_CLK(no_underflow, pop |-> !status.empty, "pop from an empty queue")

endmodule

### hw/rtl/lrs_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrs_back import lrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type status,
   input  entry_type        pop_data,
   output logic             pop,
   lrs_rsp_if.source        rsp_ch
);

   result_type out_ff, second_ff;
   logic       valid_ff, have_second_ff;
   logic       advance;

   assign advance = !valid_ff || rsp_ch.ready;
   assign pop     = advance && !have_second_ff && !status.empty;

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.coeff       = out_ff.coeff;
   assign rsp_ch.coeff_index = out_ff.coeff_index;
   assign rsp_ch.poly_done   = out_ff.poly_done;

   always_ff @(posedge clock) begin
      if (advance) begin
         if (have_second_ff) begin
            out_ff <= second_ff;
         end else if (!status.empty) begin
            out_ff    <= pop_data.first;
            second_ff <= pop_data.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         have_second_ff <= 1'b0;
      end else if (advance) begin
         if (have_second_ff) begin
            valid_ff       <= 1'b1;
            have_second_ff <= 1'b0;
         end else if (!status.empty) begin
            valid_ff       <= 1'b1;
            have_second_ff <= pop_data.two;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   `ASSERT_CLK(second_behind_first, have_second_ff |-> valid_ff,
               "second coefficient held without a beat on the output")

endmodule

### hw/rtl/lattice_rejection_sampler_top.sv
`timescale 1ns / 1ps
// A coefficient passes from its last accepted byte through a queue slot and the output
// register to rsp_ch. The input takes one byte per cycle while the queue is not full;
// the output register sends one coefficient per cycle while rsp_ch is ready.
// A four-entry queue between the classifier and the output stage absorbs the bursts.
// Reset is synchronous and active high; it clears the counters, the queue and the
// registers to uniform mode with modulus 8380417.

module lattice_rejection_sampler_top import lrs_pkg::*; #(
   parameter int COEFF_COUNT = 256,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   lrs_req_if.sink                req_ch,
   lrs_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   queue_status_type status;
   logic             push, pop;
   entry_type        push_data, pop_data;

   lrs_front #(
      .COEFF_COUNT (COEFF_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .push      (push),
      .push_data (push_data)
   );

   lrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   lrs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
